// ===== src/point_transform_3d_top_macros.svh =====
// Assertion macros for the point transform block.
// Included by point_transform_3d_top; expects clk and rst_n in scope.
`ifndef POINT_TRANSFORM_3D_TOP_MACROS_SVH
`define POINT_TRANSFORM_3D_TOP_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked only while out of reset.
`define PT3D_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define PT3D_CHECK_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PT3D_CHECK(lbl, prop, msg)
`define PT3D_CHECK_RST(lbl, prop, msg)
`endif
`endif

// ===== src/pt3d_pkg.sv =====
// Shared types, constants and arithmetic helpers of the point transform.
// No dependencies; imported by point_transform_3d_top.
package pt3d_pkg;

  localparam int COEF_FRAC_BITS = 14;
  localparam int ISO_COS_Q14    = 14189;
  localparam int ISO_SIN_Q14    = 8192;
  localparam int ZOOM_FRAC_BITS = 8;

  localparam logic signed [33:0] ZOOM_ROUND = 34'((1 << ZOOM_FRAC_BITS) - 1);
  localparam logic signed [49:0] FIX_ROUND  = 50'((1 << COEF_FRAC_BITS) - 1);
  localparam logic signed [49:0] SAT_HI     = 50'sd2147483647;
  localparam logic signed [49:0] SAT_LO     = -50'sd2147483648;

  // Pipeline stage indexes.
  localparam int S_MUL    = 0;
  localparam int S_SCL    = 1;
  localparam int S_ISOADD = 2;
  localparam int S_ISOMUL = 3;
  localparam int S_ISO    = 4;
  localparam int S_RXM    = 5;
  localparam int S_RXS    = 6;
  localparam int S_RYM    = 7;
  localparam int S_RYS    = 8;
  localparam int S_RZM    = 9;
  localparam int S_OUT    = 10;
  localparam int NSTAGES  = 11;

  typedef enum logic [2:0] {
    REG_OFFSET_X = 3'd0,
    REG_OFFSET_Y = 3'd1,
    REG_ZOOM     = 3'd2,
    REG_ISO_EN   = 3'd3,
    REG_ROT_X    = 3'd4,
    REG_ROT_Y    = 3'd5,
    REG_ROT_Z    = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] z;
    logic signed [31:0] y;
    logic signed [31:0] x;
  } vec_t;

  // Products of one rotation: a*c, b*s, a*s, b*c, plus the untouched axis.
  typedef struct packed {
    logic signed [47:0] p_ac;
    logic signed [47:0] p_bs;
    logic signed [47:0] p_as;
    logic signed [47:0] p_bc;
    logic signed [31:0] pass;
  } rot_prod_t;

  // Divide by 256 with truncation toward zero.
  function automatic logic signed [31:0] scale_div(input logic signed [33:0] p);
    logic signed [33:0] adj;
    adj = p + (p[33] ? ZOOM_ROUND : 34'sd0);
    return 32'(adj >>> ZOOM_FRAC_BITS);
  endfunction

  // Divide by 2^COEF_FRAC_BITS toward zero, then clamp to 32 bits.
  function automatic logic signed [31:0] fix_div(input logic signed [49:0] sum);
    logic signed [49:0] adj;
    logic signed [49:0] q;
    adj = sum + (sum[49] ? FIX_ROUND : 50'sd0);
    q   = adj >>> COEF_FRAC_BITS;
    if (q > SAT_HI) begin
      return SAT_HI[31:0];
    end else if (q < SAT_LO) begin
      return SAT_LO[31:0];
    end
    return q[31:0];
  endfunction

  function automatic rot_prod_t rot_mul(input logic signed [31:0] a,
                                        input logic signed [31:0] b,
                                        input logic [31:0] coeffs,
                                        input logic signed [31:0] pass);
    rot_prod_t r;
    logic signed [15:0] c;
    logic signed [15:0] s;
    c      = $signed(coeffs[15:0]);
    s      = $signed(coeffs[31:16]);
    r.p_ac = 48'(a) * 48'(c);
    r.p_bs = 48'(b) * 48'(s);
    r.p_as = 48'(a) * 48'(s);
    r.p_bc = 48'(b) * 48'(c);
    r.pass = pass;
    return r;
  endfunction

  // a*c + b*s
  function automatic logic signed [31:0] rot_first(input rot_prod_t p);
    return fix_div(50'(p.p_ac) + 50'(p.p_bs));
  endfunction

  // b*c - a*s
  function automatic logic signed [31:0] rot_second(input rot_prod_t p);
    return fix_div(50'(p.p_bc) - 50'(p.p_as));
  endfunction

endpackage

// ===== src/point_transform_3d_top.sv =====
// Point transform: offset, Q8.8 zoom, optional isometric step, three rotations.
// Depends on pt3d_pkg and point_transform_3d_top_macros.svh.
// One point is accepted per clock while in_tready is high, and its
// result passes through the eleven-stage pipeline (multiply and sum
// stages alternate for the zoom, isometric and each rotation step). Each
// stage has its own valid bit and stalls only when it is full and the stage
// after it cannot move, so bubbles are squeezed out while the output waits.
// Configuration registers are read directly by the stages and must only be
// written while no item is in flight.
`include "point_transform_3d_top_macros.svh"

module point_transform_3d_top
  import pt3d_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,    // in_x [15:0], in_y [31:16], in_z [47:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [95:0] out_tdata,   // out_x [31:0], out_y [63:32], out_z [95:64]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  // Configuration registers.
  logic signed [15:0] off_x_r, off_y_r;
  logic [15:0]        zoom_r;
  logic               iso_en_r;
  logic [31:0]        rot_x_r, rot_y_r, rot_z_r;
  cfg_reg_t           cfg_idx;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_reg_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r  <= '0;
      off_y_r  <= '0;
      zoom_r   <= 16'd256;
      iso_en_r <= 1'b1;
      rot_x_r  <= 32'd16384;
      rot_y_r  <= 32'd16384;
      rot_z_r  <= 32'd16384;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_OFFSET_X: off_x_r  <= $signed(cfg_pwdata[15:0]);
        REG_OFFSET_Y: off_y_r  <= $signed(cfg_pwdata[15:0]);
        REG_ZOOM:     zoom_r   <= cfg_pwdata[15:0];
        REG_ISO_EN:   iso_en_r <= cfg_pwdata[0];
        REG_ROT_X:    rot_x_r  <= cfg_pwdata;
        REG_ROT_Y:    rot_y_r  <= cfg_pwdata;
        REG_ROT_Z:    rot_z_r  <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_OFFSET_X: cfg_prdata = {{16{off_x_r[15]}}, off_x_r};
      REG_OFFSET_Y: cfg_prdata = {{16{off_y_r[15]}}, off_y_r};
      REG_ZOOM:     cfg_prdata = {16'd0, zoom_r};
      REG_ISO_EN:   cfg_prdata = {31'd0, iso_en_r};
      REG_ROT_X:    cfg_prdata = rot_x_r;
      REG_ROT_Y:    cfg_prdata = rot_y_r;
      REG_ROT_Z:    cfg_prdata = rot_z_r;
      default:      cfg_prdata = '0;
    endcase
  end

  // Pipeline control: a stage may load when it is empty or its item moves on.
  logic [NSTAGES-1:0] v_r;
  logic [NSTAGES-1:0] en;

  always_comb begin
    en[S_OUT] = !v_r[S_OUT] || out_tready;
    for (int k = NSTAGES - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < NSTAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_tready  = en[S_MUL];
  assign out_tvalid = v_r[S_OUT];

  // Offset and zoom multiply.
  logic signed [16:0] xa, ya, zoom_s;
  logic signed [33:0] px_r, py_r, pz_r;

  assign xa     = 17'($signed(in_tdata[15:0])) + 17'(off_x_r);
  assign ya     = 17'($signed(in_tdata[31:16])) + 17'(off_y_r);
  assign zoom_s = $signed({1'b0, zoom_r});

  always_ff @(posedge clk) begin
    if (en[S_MUL]) begin
      px_r <= 34'(xa) * 34'(zoom_s);
      py_r <= 34'(ya) * 34'(zoom_s);
      pz_r <= 34'($signed(in_tdata[47:32])) * 34'(zoom_s);
    end
  end

  // Zoom truncation.
  vec_t sc_r;

  always_ff @(posedge clk) begin
    if (en[S_SCL]) begin
      sc_r.x <= scale_div(px_r);
      sc_r.y <= scale_div(py_r);
      sc_r.z <= scale_div(pz_r);
    end
  end

  // Isometric pre-adds.
  logic signed [32:0] dif_r, sum_r;
  vec_t               sc2_r;

  always_ff @(posedge clk) begin
    if (en[S_ISOADD]) begin
      dif_r <= 33'(sc_r.x) - 33'(sc_r.y);
      sum_r <= 33'(sc_r.x) + 33'(sc_r.y);
      sc2_r <= sc_r;
    end
  end

  // Isometric products.
  logic signed [49:0] mx_r, my_r;
  vec_t               sc3_r;

  always_ff @(posedge clk) begin
    if (en[S_ISOMUL]) begin
      mx_r  <= 50'(dif_r) * 50'(ISO_COS_Q14);
      my_r  <= 50'(sum_r) * 50'(ISO_SIN_Q14) - (50'(sc2_r.z) <<< COEF_FRAC_BITS);
      sc3_r <= sc2_r;
    end
  end

  // Isometric result or bypass.
  vec_t iso_r;

  always_ff @(posedge clk) begin
    if (en[S_ISO]) begin
      iso_r.z <= sc3_r.z;
      if (iso_en_r) begin
        iso_r.x <= fix_div(mx_r);
        iso_r.y <= fix_div(my_r);
      end else begin
        iso_r.x <= sc3_r.x;
        iso_r.y <= sc3_r.y;
      end
    end
  end

  // Rotation about x: a = y, b = z, x passes.
  rot_prod_t rxp_r;
  vec_t      rx_r;

  always_ff @(posedge clk) begin
    if (en[S_RXM]) begin
      rxp_r <= rot_mul(iso_r.y, iso_r.z, rot_x_r, iso_r.x);
    end
    if (en[S_RXS]) begin
      rx_r.x <= rxp_r.pass;
      rx_r.y <= rot_first(rxp_r);
      rx_r.z <= rot_second(rxp_r);
    end
  end

  // Rotation about y: a = x, b = z, y passes.
  rot_prod_t ryp_r;
  vec_t      ry_r;

  always_ff @(posedge clk) begin
    if (en[S_RYM]) begin
      ryp_r <= rot_mul(rx_r.x, rx_r.z, rot_y_r, rx_r.y);
    end
    if (en[S_RYS]) begin
      ry_r.x <= rot_first(ryp_r);
      ry_r.y <= ryp_r.pass;
      ry_r.z <= rot_second(ryp_r);
    end
  end

  // Rotation about z: a = y, b = x, so b*c - a*s is the new x.
  rot_prod_t rzp_r;
  vec_t      out_r;

  always_ff @(posedge clk) begin
    if (en[S_RZM]) begin
      rzp_r <= rot_mul(ry_r.y, ry_r.x, rot_z_r, ry_r.z);
    end
    if (en[S_OUT]) begin
      out_r.x <= rot_second(rzp_r);
      out_r.y <= rot_first(rzp_r);
      out_r.z <= rzp_r.pass;
    end
  end

  assign out_tdata = out_r;

  `PT3D_CHECK_RST(a_reset_empties, !rst_n |=> !out_tvalid, "output valid after reset")
  `PT3D_CHECK(a_accept_enters, (in_tvalid && in_tready) |=> v_r[S_MUL],
              "accepted item missing from first stage")
  `PT3D_CHECK(a_full_blocks, (&v_r && !out_tready) |-> !in_tready,
              "input accepted into a full stalled pipeline")
  `PT3D_CHECK(a_stall_has_room,
              (in_tready && out_tvalid && !out_tready) |-> ($countones(v_r) < NSTAGES),
              "input ready while no stage is free")

endmodule
